FILE: rtl/b64d_pkg.sv
// b64d_pkg: shared constants and types for the base64 stream decoder.
// Used by b64d_sextet, b64d_core and base64_stream_decoder_top; depends on nothing.
package b64d_pkg;

   // Character codes
   localparam logic [7:0] PAD_CHAR  = 8'h3d;
   localparam logic [7:0] DASH_CHAR = 8'h2d;
   localparam logic [7:0] STAR_CHAR = 8'h2a;
   localparam logic [7:0] UPPER_A   = 8'h41;
   localparam logic [7:0] LOWER_A   = 8'h61;
   localparam logic [7:0] DIGIT_0   = 8'h30;

   localparam logic [7:0] LETTER_COUNT = 8'd26;
   localparam logic [7:0] DIGIT_COUNT  = 8'd10;

   localparam logic [5:0] LOWER_BASE = 6'd26;
   localparam logic [5:0] DIGIT_BASE = 6'd52;
   localparam logic [5:0] DASH_VALUE = 6'd62;
   localparam logic [5:0] STAR_VALUE = 6'd63;

   // Positions within a quartet
   localparam logic [1:0] POS_0 = 2'd0;
   localparam logic [1:0] POS_1 = 2'd1;
   localparam logic [1:0] POS_2 = 2'd2;
   localparam logic [1:0] POS_3 = 2'd3;

   localparam logic [15:0] LIMIT_RESET = 16'hffff;

   typedef struct packed {
      logic       valid;   // character belongs to the alphabet
      logic       pad;     // character is '='
      logic [5:0] value;
   } sextet_type;

   typedef struct packed {
      logic [7:0]  byte_out;
      logic        byte_valid;
      logic        msg_done;
      logic        msg_ok;
      logic [15:0] bytes_written;
   } rsp_type;

endpackage

FILE: rtl/b64d_sextet.sv
// b64d_sextet: maps one ASCII character to its 6-bit alphabet value.
// Depends on b64d_pkg for character codes and sextet_type.
module b64d_sextet (
   input  logic [7:0]           char_in,
   output b64d_pkg::sextet_type sextet
);

   logic [7:0] off_upper;
   logic [7:0] off_lower;
   logic [7:0] off_digit;

   assign off_upper = char_in - b64d_pkg::UPPER_A;
   assign off_lower = char_in - b64d_pkg::LOWER_A;
   assign off_digit = char_in - b64d_pkg::DIGIT_0;

   always_comb begin
      sextet.valid = 1'b1;
      sextet.pad   = 1'b0;
      sextet.value = '0;
      // wrapped offsets fall above the range, so one compare checks both ends
      if (off_upper < b64d_pkg::LETTER_COUNT) begin
         sextet.value = off_upper[5:0];
      end else if (off_lower < b64d_pkg::LETTER_COUNT) begin
         sextet.value = off_lower[5:0] + b64d_pkg::LOWER_BASE;
      end else if (off_digit < b64d_pkg::DIGIT_COUNT) begin
         sextet.value = off_digit[5:0] + b64d_pkg::DIGIT_BASE;
      end else if (char_in == b64d_pkg::DASH_CHAR) begin
         sextet.value = b64d_pkg::DASH_VALUE;
      end else if (char_in == b64d_pkg::STAR_CHAR) begin
         sextet.value = b64d_pkg::STAR_VALUE;
      end else begin
         sextet.valid = 1'b0;
         sextet.pad   = (char_in == b64d_pkg::PAD_CHAR);
      end
   end

endmodule

FILE: rtl/b64d_core.sv
// b64d_core: per-message decode state and the result for one character.
// Depends on b64d_pkg and b64d_sextet.
module b64d_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,     // request moves on to the result register
   input  logic [7:0]          char_in,
   input  logic                last_char,
   input  logic [15:0]         out_limit,
   output b64d_pkg::rsp_type   rsp
);

   b64d_pkg::sextet_type sx;

   logic [1:0]  pos_ff;
   logic [5:0]  held_ff;
   logic        pad_ff;
   logic        failed_ff;
   logic [15:0] count_ff;

   logic [5:0]  held_in;
   logic        pad_in;
   logic        failed_in;
   logic [15:0] count_in;
   logic        have_byte;
   logic [7:0]  byte_val;

   b64d_sextet u_sextet (
      .char_in (char_in),
      .sextet  (sx)
   );

   always_comb begin
      held_in   = held_ff;
      pad_in    = pad_ff;
      failed_in = failed_ff;
      count_in  = count_ff;
      have_byte = 1'b0;
      byte_val  = '0;
      if (!failed_ff) begin
         if (sx.pad) begin
            // '=' in position 2 must be followed by a final '='
            if (pos_ff == b64d_pkg::POS_2 && !last_char) begin
               pad_in = 1'b1;
            end else if (pos_ff == b64d_pkg::POS_3 && last_char) begin
               pad_in = 1'b1;
            end else begin
               failed_in = 1'b1;
            end
         end else if (!sx.valid || pad_ff) begin
            failed_in = 1'b1;
         end else begin
            case (pos_ff)
               b64d_pkg::POS_1: begin
                  byte_val  = {held_ff, sx.value[5:4]};
                  have_byte = 1'b1;
               end
               b64d_pkg::POS_2: begin
                  byte_val  = {held_ff[3:0], sx.value[5:2]};
                  have_byte = 1'b1;
               end
               b64d_pkg::POS_3: begin
                  byte_val  = {held_ff[1:0], sx.value};
                  have_byte = 1'b1;
               end
               default: ;
            endcase
            held_in = sx.value;
         end
         if (have_byte) begin
            if (count_ff < out_limit) begin
               count_in = count_ff + 16'd1;
            end else begin
               have_byte = 1'b0;
            end
         end
         // length 1 modulo 4
         if (last_char && !failed_in && pos_ff == b64d_pkg::POS_0) begin
            failed_in = 1'b1;
         end
      end
   end

   always_comb begin
      rsp.byte_out      = have_byte ? byte_val : 8'd0;
      rsp.byte_valid    = have_byte;
      rsp.msg_done      = last_char;
      rsp.msg_ok        = last_char && !failed_in;
      rsp.bytes_written = last_char ? count_in : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= b64d_pkg::POS_0;
         held_ff   <= '0;
         pad_ff    <= 1'b0;
         failed_ff <= 1'b0;
         count_ff  <= '0;
      end else if (enable) begin
         if (last_char) begin
            pos_ff    <= b64d_pkg::POS_0;
            held_ff   <= '0;
            pad_ff    <= 1'b0;
            failed_ff <= 1'b0;
            count_ff  <= '0;
         end else begin
            pos_ff    <= pos_ff + 2'd1;
            held_ff   <= held_in;
            pad_ff    <= pad_in;
            failed_ff <= failed_in;
            count_ff  <= count_in;
         end
      end
   end

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      enable && last_char |=> pos_ff == b64d_pkg::POS_0 && count_ff == 16'd0 && !failed_ff)
      else $error("state not cleared after last character");

   a_no_byte_pos0: assert property (@(posedge clock) disable iff (reset)
      rsp.byte_valid |-> pos_ff != b64d_pkg::POS_0 && !failed_ff)
      else $error("byte emitted in position 0 or after failure");

   a_fail_sticks: assert property (@(posedge clock) disable iff (reset)
      enable && failed_ff && !last_char |=> failed_ff)
      else $error("failure cleared before end of message");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      enable && !last_char |=>
         count_ff == $past(count_ff) || count_ff == $past(count_ff) + 16'd1)
      else $error("byte count jumped");

endmodule

FILE: rtl/base64_stream_decoder_top.sv
// base64_stream_decoder_top: request register, decode core, result register, limit CSR.
// Depends on b64d_pkg and b64d_core.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_char_in[7:0], req_last_char
//   rsp      out        rsp_valid/rsp_ready  rsp_byte_out[7:0], rsp_byte_valid, rsp_msg_done,
//                                            rsp_msg_ok, rsp_bytes_written[15:0]
//   csr      in         csr_write_en         csr_write_data[15:0] (out_limit)
//
// One request per cycle sustained while the receiver keeps rsp_ready high.
// The decode of a character sits between the request register and the result register;
// message state updates as the request moves into the result register.
// Synchronous reset clears the pipeline, the message state and sets out_limit to 65535.
// A stalled result holds; the request register still fills, so one more request is taken.
module base64_stream_decoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_in,
   input  logic        req_last_char,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_byte_out,
   output logic        rsp_byte_valid,
   output logic        rsp_msg_done,
   output logic        rsp_msg_ok,
   output logic [15:0] rsp_bytes_written,
   input  logic        csr_write_en,
   input  logic [15:0] csr_write_data
);

   logic              s1_valid_ff;
   logic [7:0]        s1_char_ff;
   logic              s1_last_ff;
   logic              rsp_valid_ff;
   b64d_pkg::rsp_type rsp_ff;
   b64d_pkg::rsp_type rsp_in;
   logic [15:0]       limit_ff;
   logic              out_free;
   logic              s1_adv;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;

   b64d_core u_core (
      .clock     (clock),
      .reset     (reset),
      .enable    (s1_adv),
      .char_in   (s1_char_ff),
      .last_char (s1_last_ff),
      .out_limit (limit_ff),
      .rsp       (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= b64d_pkg::LIMIT_RESET;
      end else begin
         if (csr_write_en) begin
            limit_ff <= csr_write_data;
         end
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   // payload: load on advance only
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_char_ff <= req_char_in;
         s1_last_ff <= req_last_char;
      end
      if (s1_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_byte_out      = rsp_ff.byte_out;
   assign rsp_byte_valid    = rsp_ff.byte_valid;
   assign rsp_msg_done      = rsp_ff.msg_done;
   assign rsp_msg_ok        = rsp_ff.msg_ok;
   assign rsp_bytes_written = rsp_ff.bytes_written;

endmodule

FILE: test/tb_base64_stream_decoder_top.sv
// tb_base64_stream_decoder_top: self-checking bench for the base64 stream decoder.
// Checks every result against a built-in decode predictor, or against the fixed result of a typed
// directed row; depends on b64d_pkg and base64_stream_decoder_top.
module tb_base64_stream_decoder_top;

   localparam int          PHASES       = 6;
   localparam int          PHASE_ITEMS  = 65;
   localparam int          DIR_ROWS     = 25;
   localparam int          LONG_HOLD    = 60;
   localparam int          DRAIN_CYCLES = 8;
   localparam int unsigned CYCLE_LIMIT  = 200000;

   typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_type;

   typedef struct packed {
      logic [7:0]        ch;
      logic              last;
      logic              typed;
      b64d_pkg::rsp_type rsp;
   } dir_row_type;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_in    = 8'h00;
   logic        req_last_char  = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready      = 1'b0;
   logic [7:0]  rsp_byte_out;
   logic        rsp_byte_valid;
   logic        rsp_msg_done;
   logic        rsp_msg_ok;
   logic [15:0] rsp_bytes_written;
   logic        csr_write_en   = 1'b0;
   logic [15:0] csr_write_data = 16'h0000;

   // decode predictor state
   logic [1:0]  pos_s     = b64d_pkg::POS_0;
   logic [5:0]  held_s    = 6'd0;
   logic        pad_s     = 1'b0;
   logic        failed_s  = 1'b0;
   logic [15:0] count_s   = 16'd0;
   logic [15:0] limit_s   = b64d_pkg::LIMIT_RESET;

   b64d_pkg::rsp_type decoded_q[$];
   logic [8:0]        stream_q[$];
   dir_row_type       dir_rows[DIR_ROWS];
   int unsigned  burst_left    = 0;
   int unsigned  mismatch_count = 0;
   int unsigned  result_index  = 0;
   int unsigned  cycle_count   = 0;
   bit           hold_request  = 1'b0;

   base64_stream_decoder_top u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_in       (req_char_in),
      .req_last_char     (req_last_char),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_byte_out      (rsp_byte_out),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_msg_done      (rsp_msg_done),
      .rsp_msg_ok        (rsp_msg_ok),
      .rsp_bytes_written (rsp_bytes_written),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data)
   );

   always #10 clock = ~clock;

   function automatic int alpha_value(input logic [7:0] c);
      if (c >= b64d_pkg::UPPER_A && c < b64d_pkg::UPPER_A + b64d_pkg::LETTER_COUNT)
         return int'(c - b64d_pkg::UPPER_A);
      if (c >= b64d_pkg::LOWER_A && c < b64d_pkg::LOWER_A + b64d_pkg::LETTER_COUNT)
         return int'(c - b64d_pkg::LOWER_A) + 26;
      if (c >= b64d_pkg::DIGIT_0 && c < b64d_pkg::DIGIT_0 + b64d_pkg::DIGIT_COUNT)
         return int'(c - b64d_pkg::DIGIT_0) + 52;
      if (c == b64d_pkg::DASH_CHAR) return 62;
      if (c == b64d_pkg::STAR_CHAR) return 63;
      return -1;
   endfunction

   function automatic logic [7:0] sextet_char(input int unsigned v);
      if (v < b64d_pkg::LOWER_BASE) return b64d_pkg::UPPER_A + 8'(v);
      if (v < b64d_pkg::DIGIT_BASE) return b64d_pkg::LOWER_A + 8'(v - b64d_pkg::LOWER_BASE);
      if (v < b64d_pkg::DASH_VALUE) return b64d_pkg::DIGIT_0 + 8'(v - b64d_pkg::DIGIT_BASE);
      if (v == b64d_pkg::DASH_VALUE) return b64d_pkg::DASH_CHAR;
      return b64d_pkg::STAR_CHAR;
   endfunction

   // Advance the predictor by one character and return the result it implies.
   function automatic b64d_pkg::rsp_type decode_char(input logic [7:0] c, input logic lst);
      b64d_pkg::rsp_type r;
      int                v;
      logic [7:0]        b;
      logic              got;
      r   = '0;
      b   = 8'h00;
      got = 1'b0;
      if (!failed_s) begin
         v = alpha_value(c);
         if (c == b64d_pkg::PAD_CHAR) begin
            if ((pos_s == b64d_pkg::POS_2 && !lst) || (pos_s == b64d_pkg::POS_3 && lst))
               pad_s = 1'b1;
            else
               failed_s = 1'b1;
         end else if (v < 0 || pad_s) begin
            failed_s = 1'b1;
         end else begin
            case (pos_s)
               b64d_pkg::POS_1: b = {held_s, v[5:4]};
               b64d_pkg::POS_2: b = {held_s[3:0], v[5:2]};
               b64d_pkg::POS_3: b = {held_s[1:0], v[5:0]};
               default: b = 8'h00;
            endcase
            got    = (pos_s != b64d_pkg::POS_0);
            held_s = v[5:0];
         end
         if (got) begin
            if (count_s < limit_s) count_s = count_s + 16'd1;
            else got = 1'b0;
         end
         // a message may not stop one character into a quartet
         if (lst && !failed_s && pos_s == b64d_pkg::POS_0) failed_s = 1'b1;
      end
      r.byte_out      = got ? b : 8'h00;
      r.byte_valid    = got;
      r.msg_done      = lst;
      r.msg_ok        = lst && !failed_s;
      r.bytes_written = lst ? count_s : 16'd0;
      if (lst) begin
         pos_s    = b64d_pkg::POS_0;
         held_s   = 6'd0;
         pad_s    = 1'b0;
         failed_s = 1'b0;
         count_s  = 16'd0;
      end else begin
         pos_s = pos_s + 2'd1;
      end
      return r;
   endfunction

   function automatic dir_row_type free_row(input logic [7:0] c, input logic lst);
      dir_row_type row;
      row       = '0;
      row.ch    = c;
      row.last  = lst;
      return row;
   endfunction

   function automatic dir_row_type typed_row(input logic [7:0] c, input logic lst,
                                             input logic [7:0] bo, input logic bv,
                                             input logic ok, input logic [15:0] bw);
      dir_row_type row;
      row                   = free_row(c, lst);
      row.typed             = 1'b1;
      row.rsp.byte_out      = bo;
      row.rsp.byte_valid    = bv;
      row.rsp.msg_done      = lst;
      row.rsp.msg_ok        = ok;
      row.rsp.bytes_written = bw;
      return row;
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH @%0t result %0d: %s", $time, result_index, what);
      mismatch_count++;
   endtask

   // Offer one request, idling between bursts, and record its expected result on acceptance.
   task automatic offer_char(input logic [7:0] c, input logic lst,
                             input logic typed, input b64d_pkg::rsp_type typed_rsp);
      int unsigned       gap;
      b64d_pkg::rsp_type predicted;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_char_in   <= c;
      req_last_char <= lst;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = decode_char(c, lst);
      decoded_q.push_back(typed ? typed_rsp : predicted);
   endtask

   // Drain the pipeline, then write out_limit.
   task automatic write_limit(input logic [15:0] value);
      req_valid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      limit_s = value;
   endtask

   // Mostly well-formed messages with random content; the rest is noise and broken framing.
   task automatic queue_message();
      logic [7:0]  msg[$];
      int unsigned n;
      int unsigned k;
      if ($urandom_range(0, 3) != 0) begin
         n = $urandom_range(2, 13);
         if (n % 4 == 1) n++;
         for (k = 0; k < n; k++) msg.push_back(sextet_char($urandom_range(0, 63)));
         if (n % 4 == 2 && $urandom_range(0, 1) == 1) begin
            msg.push_back(b64d_pkg::PAD_CHAR);
            msg.push_back(b64d_pkg::PAD_CHAR);
         end else if (n % 4 == 3 && $urandom_range(0, 1) == 1) begin
            msg.push_back(b64d_pkg::PAD_CHAR);
         end
      end else begin
         n = $urandom_range(1, 9);
         for (k = 0; k < n; k++) begin
            case ($urandom_range(0, 4))
               0, 1:    msg.push_back(8'($urandom_range(0, 255)));
               2:       msg.push_back(b64d_pkg::PAD_CHAR);
               default: msg.push_back(sextet_char($urandom_range(0, 63)));
            endcase
         end
      end
      for (k = 0; k < msg.size(); k++) stream_q.push_back({k == msg.size() - 1, msg[k]});
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin : result_check
      b64d_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (decoded_q.size() == 0) begin
            report_mismatch("result with no request outstanding");
         end else begin
            want = decoded_q.pop_front();
            if (rsp_byte_out !== want.byte_out)
               report_mismatch($sformatf("byte_out %h, want %h", rsp_byte_out, want.byte_out));
            if (rsp_byte_valid !== want.byte_valid)
               report_mismatch($sformatf("byte_valid %b, want %b",
                                         rsp_byte_valid, want.byte_valid));
            if (rsp_msg_done !== want.msg_done)
               report_mismatch($sformatf("msg_done %b, want %b", rsp_msg_done, want.msg_done));
            if (rsp_msg_ok !== want.msg_ok)
               report_mismatch($sformatf("msg_ok %b, want %b", rsp_msg_ok, want.msg_ok));
            if (rsp_bytes_written !== want.bytes_written)
               report_mismatch($sformatf("bytes_written %0d, want %0d",
                                         rsp_bytes_written, want.bytes_written));
         end
         result_index++;
      end
   end

   // Receiver pacing: stretches of full rate, random stalls and a fixed pattern.
   initial begin : rsp_pacing
      stall_mode_type mode;
      int unsigned    left;
      int unsigned    tick;
      mode = STALL_NONE;
      left = 0;
      tick = 0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_request) begin
            // hold off long enough for the block to back up onto its input
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         if (left == 0) begin
            mode = stall_mode_type'($urandom_range(0, 2));
            left = $urandom_range(10, 60);
         end
         left--;
         case (mode)
            STALL_NONE:   rsp_ready <= 1'b1;
            STALL_RANDOM: rsp_ready <= ($urandom_range(0, 2) != 0);
            default:      rsp_ready <= (tick % 4 != 3);
         endcase
      end
   end

   initial begin : stimulus
      int          phase;
      int          k;
      logic [15:0] lim;
      logic [8:0]  item;

      dir_rows = '{
         typed_row("T", 1'b0, 8'h00, 1'b0, 1'b0, 16'd0),
         typed_row("W", 1'b0, 8'h4d, 1'b1, 1'b0, 16'd0),
         typed_row("F", 1'b0, 8'h61, 1'b1, 1'b0, 16'd0),
         typed_row("u", 1'b1, 8'h6e, 1'b1, 1'b1, 16'd3),
         typed_row("A", 1'b0, 8'h00, 1'b0, 1'b0, 16'd0),
         typed_row("A", 1'b1, 8'h00, 1'b1, 1'b1, 16'd1),
         typed_row("*", 1'b0, 8'h00, 1'b0, 1'b0, 16'd0),
         typed_row("*", 1'b1, 8'hff, 1'b1, 1'b1, 16'd1),
         typed_row("Q", 1'b0, 8'h00, 1'b0, 1'b0, 16'd0),
         typed_row("Q", 1'b0, 8'h41, 1'b1, 1'b0, 16'd0),
         typed_row(b64d_pkg::PAD_CHAR, 1'b0, 8'h00, 1'b0, 1'b0, 16'd0),
         typed_row(b64d_pkg::PAD_CHAR, 1'b1, 8'h00, 1'b0, 1'b1, 16'd1),
         typed_row("A", 1'b1, 8'h00, 1'b0, 1'b0, 16'd0),
         free_row("z", 1'b0),
         free_row("!", 1'b0),
         free_row("9", 1'b1),
         free_row("A", 1'b0),
         free_row("B", 1'b0),
         free_row(b64d_pkg::PAD_CHAR, 1'b1),
         free_row(b64d_pkg::PAD_CHAR, 1'b0),
         free_row("A", 1'b1),
         free_row("0", 1'b0),
         free_row("-", 1'b0),
         free_row("a", 1'b0),
         free_row(b64d_pkg::PAD_CHAR, 1'b1)
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         offer_char(dir_rows[i].ch, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].rsp);

      // phases may end mid-message, so the limit also changes under a message in flight
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       lim = 16'd0;
            1:       lim = 16'd1;
            2:       lim = 16'hffff;
            3:       lim = 16'd2;
            4:       lim = 16'($urandom_range(0, 65535));
            default: lim = 16'($urandom_range(0, 8));
         endcase
         write_limit(lim);
         if (phase == 2) hold_request = 1'b1;
         for (k = 0; k < PHASE_ITEMS; k++) begin
            if (stream_q.size() == 0) queue_message();
            item = stream_q.pop_front();
            offer_char(item[7:0], item[8], 1'b0, '0);
         end
      end
      while (stream_q.size() != 0) begin
         item = stream_q.pop_front();
         offer_char(item[7:0], item[8], 1'b0, '0);
      end

      req_valid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
